// ===== hw/rtl/toeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_pkg: shared definitions for the time-ordered event queue
// Sizes, operation and status codes, and the controller command word.
// ----------------------------------------------------------------------------
package toeq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_BITS   = 32;
   localparam int TAG_BITS    = 16;

   // count runs from zero up to the depth itself
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // stream word widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = ((TIME_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * TIME_BITS + TAG_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      FN_SCHED_ABS   = 2'd0,
      FN_SCHED_DELAY = 2'd1,
      FN_POP         = 2'd2,
      FN_POP_DUE     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_LATE  = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;   // latch the incoming word and form its event time
      logic execute;   // run the queue operation and load the result
   } cmd_type;

endpackage

// ===== hw/rtl/time_ordered_event_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core: bounded event queue for a simulation kernel
// Channel  Dir  tuser         tdata (lowest bit up)
// req_     in   func          time_value, event_tag
// rsp_     out  status        out_tag, out_time, now_time
//
// Each word is first captured and its event time formed
// (saturating add of the delay to the current time), then put through the
// compare across all queue cells and the shift that inserts or pops.
// A result waits in the output register; the next word is taken meanwhile
// and executes once that result has gone.
// Reset clears the event count and current time; cell contents are left.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [toeq_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // time_value, event_tag
   input  logic [1:0]                           req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [toeq_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // out_tag, out_time, now_time
   output logic [1:0]                           rsp_tuser   // status
);
   import toeq_pkg::*;

   cmd_type              cmd;
   logic [1:0]           res_status;
   logic [TAG_BITS-1:0]  res_tag;
   logic [TIME_BITS-1:0] res_time;
   logic [TIME_BITS-1:0] res_now;

   // sequencing: when to take a word and when to run it
   toeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // sorted store, current time and held result
   toeq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_func    (req_tuser),
      .in_time    (req_tdata[TIME_BITS-1:0]),
      .in_tag     (req_tdata[TIME_BITS +: TAG_BITS]),
      .res_status (res_status),
      .res_tag    (res_tag),
      .res_time   (res_time),
      .res_now    (res_now)
   );

   // pack the result word, padding bits zero
   assign rsp_tdata = RSP_DATA_BITS'({res_now, res_time, res_tag});
   assign rsp_tuser = res_status;

endmodule

// ===== hw/rtl/toeq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_ctrl: sequencing for the event queue
// Two-state machine: take a word, then execute it once the result slot frees.
// ----------------------------------------------------------------------------
module toeq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output toeq_pkg::cmd_type cmd
);
   import toeq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the previous result has gone
            if (slot_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_EXEC)
      else $error("accepted word did not move to execute");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_tvalid || rsp_tready))
      else $error("execute would overwrite a pending result");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_tvalid)
      else $error("execute did not present a result");

   a_no_capture_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> !cmd.capture)
      else $error("capture while a word is in flight");
`endif

endmodule

// ===== hw/rtl/toeq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_dpath: sorted cell array, current time and result registers
// Every cell compares its time with the operand at once; insert shifts up,
// pop shifts down.
// ----------------------------------------------------------------------------
module toeq_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  toeq_pkg::cmd_type                  cmd,
   input  logic [1:0]                         in_func,
   input  logic [toeq_pkg::TIME_BITS-1:0]     in_time,
   input  logic [toeq_pkg::TAG_BITS-1:0]      in_tag,
   output logic [1:0]                         res_status,
   output logic [toeq_pkg::TAG_BITS-1:0]      res_tag,
   output logic [toeq_pkg::TIME_BITS-1:0]     res_time,
   output logic [toeq_pkg::TIME_BITS-1:0]     res_now
);
   import toeq_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // operand stage
   func_type             func_ff;
   logic [TIME_BITS-1:0] op_time_ff, op_time_in;
   logic [TAG_BITS-1:0]  op_tag_ff;
   logic [TIME_BITS:0]   delay_sum;

   // control state
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0] now_ff, now_in;

   // cells
   logic [TIME_BITS-1:0] time_ff [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  tag_ff  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] time_in [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  tag_in  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] le;

   // results
   status_type           status_ff, status_in;
   logic [TAG_BITS-1:0]  rtag_ff, rtag_in;
   logic [TIME_BITS-1:0] rtime_ff, rtime_in;

   logic is_sched, full, empty, late, do_ins, do_pop;

   // saturating now + delay, formed while the word is captured
   assign delay_sum = {1'b0, now_ff} + {1'b0, in_time};

   always_comb begin
      if (func_type'(in_func) == FN_SCHED_DELAY) begin
         op_time_in = delay_sum[TIME_BITS] ? TIME_MAX : delay_sum[TIME_BITS-1:0];
      end else begin
         op_time_in = in_time;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= func_type'(in_func);
         op_time_ff <= op_time_in;
         op_tag_ff  <= in_tag;
      end
   end

   assign is_sched = (func_ff == FN_SCHED_ABS) || (func_ff == FN_SCHED_DELAY);
   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign late     = (func_ff == FN_POP_DUE) && (time_ff[0] > op_time_ff);
   assign do_ins   = cmd.execute && is_sched && !full;
   assign do_pop   = cmd.execute && !is_sched && !empty && !late;

   // thermometer of occupied cells not later than the operand
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         le[k] = (CNT_BITS'(k) < count_ff) && (time_ff[k] <= op_time_ff);
      end
   end

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic [TIME_BITS-1:0] prev_time, next_time;
      logic [TAG_BITS-1:0]  prev_tag, next_tag;
      logic                 take_new;

      if (k == 0) begin : g_head
         assign prev_time = op_time_ff;
         assign prev_tag  = op_tag_ff;
         assign take_new  = 1'b1;
      end else begin : g_body
         assign prev_time = time_ff[k-1];
         assign prev_tag  = tag_ff[k-1];
         assign take_new  = le[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_tail
         assign next_time = time_ff[k];
         assign next_tag  = tag_ff[k];
      end else begin : g_link
         assign next_time = time_ff[k+1];
         assign next_tag  = tag_ff[k+1];
      end

      always_comb begin
         time_in[k] = time_ff[k];
         tag_in[k]  = tag_ff[k];
         if (do_ins && !le[k]) begin
            time_in[k] = take_new ? op_time_ff : prev_time;
            tag_in[k]  = take_new ? op_tag_ff  : prev_tag;
         end else if (do_pop) begin
            time_in[k] = next_time;
            tag_in[k]  = next_tag;
         end
      end

      always_ff @(posedge clock) begin
         time_ff[k] <= time_in[k];
         tag_ff[k]  <= tag_in[k];
      end
   end

   always_comb begin
      count_in  = count_ff;
      now_in    = now_ff;
      status_in = ST_OK;
      rtag_in   = '0;
      rtime_in  = '0;
      if (is_sched) begin
         rtime_in = op_time_ff;
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end else if (empty) begin
         status_in = ST_EMPTY;
      end else if (late) begin
         status_in = ST_LATE;
      end else begin
         rtime_in = time_ff[0];
         rtag_in  = tag_ff[0];
         now_in   = time_ff[0];
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         now_ff   <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
         now_ff   <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         rtag_ff   <= rtag_in;
         rtime_ff  <= rtime_in;
      end
   end

   assign res_status = status_ff;
   assign res_tag    = rtag_ff;
   assign res_time   = rtime_ff;
   assign res_now    = now_ff;

endmodule

// ===== sim/time_ordered_event_queue_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core_test: self-checking bench for the event queue
// Drive schedule and pop words into the core and predict every reply from a
// sorted list of pending events. Compare each reply field by field against
// the oldest prediction. The sender runs in bursts and the receiver stalls on
// patterns of its own. Phases mostly alternate between filling the queue past
// full and draining it past empty; one phase stays balanced.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_core_test;

   import toeq_pkg::*;

   localparam int ITEMS_PER_PHASE = 155;
   localparam int PHASE_COUNT     = 10;
   localparam int LONG_STALL      = 300;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 400000;

   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [TAG_BITS-1:0]  tag_type;

   typedef struct packed {
      stamp_type at;
      tag_type   tag;
   } event_entry_type;

   typedef struct packed {
      status_type status;
      tag_type    tag;
      stamp_type  at;
      stamp_type  now;
   } queue_reply_type;

   // Shadow of the queue: sorted pending events, current time and the
   // replies still owed by the core.
   class event_queue_scoreboard;
      event_entry_type pending_events[$];
      queue_reply_type expected_replies[$];
      stamp_type       sim_now;
      int              failures;

      function new();
         sim_now  = '0;
         failures = 0;
      endfunction

      // Apply one accepted word to the shadow queue and note its reply.
      function void note_word(func_type f, stamp_type tv, tag_type tag);
         queue_reply_type    r;
         event_entry_type    e;
         logic [TIME_BITS:0] sum;
         int                 pos;
         r.status = ST_OK;
         r.tag    = '0;
         r.at     = '0;
         case (f)
            FN_SCHED_ABS, FN_SCHED_DELAY: begin
               e.at = tv;
               if (f == FN_SCHED_DELAY) begin
                  // saturate when the sum runs past the largest time
                  sum  = {1'b0, sim_now} + {1'b0, tv};
                  e.at = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
               end
               e.tag = tag;
               r.at  = e.at;
               if (pending_events.size() >= QUEUE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  // equal times stay first in, first out
                  pos = 0;
                  while (pos < pending_events.size() && pending_events[pos].at <= e.at)
                     pos++;
                  pending_events.insert(pos, e);
               end
            end
            default: begin
               if (pending_events.size() == 0) begin
                  r.status = ST_EMPTY;
               end else if (f == FN_POP_DUE && pending_events[0].at > tv) begin
                  r.status = ST_LATE;
               end else begin
                  r.at    = pending_events[0].at;
                  r.tag   = pending_events[0].tag;
                  sim_now = pending_events[0].at;
                  void'(pending_events.pop_front());
               end
            end
         endcase
         r.now = sim_now;
         expected_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [TIME_BITS-1:0] exp_v,
                                  logic [TIME_BITS-1:0] act_v);
         if (exp_v !== act_v) begin
            failures++;
            $display("%0t: %s expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      // Check one reply word against the oldest prediction.
      function void check_word(logic [1:0] st, logic [RSP_DATA_BITS-1:0] d);
         queue_reply_type r;
         if (expected_replies.size() == 0) begin
            failures++;
            $display("%0t: reply with none outstanding, expected nothing, actual %0d %h",
                     $time, st, d);
         end else begin
            r = expected_replies.pop_front();
            compare_field("status",   TIME_BITS'(r.status), TIME_BITS'(st));
            compare_field("out_tag",  TIME_BITS'(r.tag), TIME_BITS'(d[TAG_BITS-1:0]));
            compare_field("out_time", r.at, d[TAG_BITS +: TIME_BITS]);
            compare_field("now_time", r.now, d[TAG_BITS+TIME_BITS +: TIME_BITS]);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // time_value, event_tag
   logic [1:0]               req_tuser;   // func
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // out_tag, out_time, now_time
   logic [1:0]               rsp_tuser;   // status

   event_queue_scoreboard sb;

   int cycle_count;
   int stall_asked;
   int stall_served;
   int stall_left;
   int rx_cycle;
   int rx_mode;
   int rx_period;

   time_ordered_event_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Abandon the run if the replies never come home.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("time_ordered_event_queue_core: mismatch");
         $finish;
      end
   end

   // Take each reply word at the edge where it is handed over.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tuser, rsp_tdata);
   end

   // Receiver: switch stall pattern every so often; honour a long hold-off
   // when the stimulus asks for one, counting it down here.
   always @(negedge clock) begin
      rx_cycle++;
      if (stall_asked != stall_served) begin
         stall_served++;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_cycle % 97 == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_period = $urandom_range(1, 5);
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (rx_cycle % rx_period) == 0;
            default: rsp_tready <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   // Offer one word and hold it until the core takes it.
   task automatic send_word(func_type f, stamp_type tv, tag_type tag);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {tag, tv};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_word(f, tv, tag);
   endtask

   // Drop valid for an idle stretch whose length n gives; zero leaves it as it is.
   task automatic idle_cycles(int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_replies_home();
      while (sb.expected_replies.size() != 0)
         @(posedge clock);
   endtask

   // One random word; sched_pct sets the share of schedules against pops.
   // Times lean towards ties, the current time, the head and the extremes.
   task automatic random_word(int sched_pct);
      func_type  f;
      stamp_type tv;
      stamp_type head;
      int        pick;
      head = (sb.pending_events.size() != 0) ? sb.pending_events[0].at
                                             : stamp_type'($urandom);
      pick = $urandom_range(0, 5);
      if ($urandom_range(0, 99) < sched_pct) begin
         f = $urandom_range(0, 1) ? FN_SCHED_DELAY : FN_SCHED_ABS;
         case (pick)
            0, 1: tv = $urandom;
            2: tv = sb.sim_now + $urandom_range(0, 3) * 32'h4000;
            3: tv = $urandom_range(0, 3) * 32'h4000;
            4: tv = '1;
            default: tv = '0;
         endcase
      end else begin
         f = $urandom_range(0, 1) ? FN_POP_DUE : FN_POP;
         case (pick)
            0: tv = $urandom;
            1: tv = head;
            2: tv = head - 1;
            3: tv = head + $urandom_range(0, 255);
            4: tv = '1;
            default: tv = '0;
         endcase
      end
      send_word(f, tv, tag_type'($urandom_range(0, 16'hFFFF)));
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int sched_pct;
      int burst_left;
      bit gaps_on;

      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      cycle_count  = 0;
      stall_asked  = 0;
      stall_served = 0;
      stall_left   = 0;
      rx_cycle     = 0;
      rx_mode      = 0;
      rx_period    = 1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pops on an empty queue
      send_word(FN_POP,        32'h0000_0000, 16'h0000);
      send_word(FN_POP_DUE,    32'hFFFF_FFFF, 16'hFFFF);
      // ties at one time, the time extremes, a zero delay tying with zero
      send_word(FN_SCHED_ABS,   32'h0001_0000, 16'hFFFF);
      send_word(FN_SCHED_ABS,   32'h0001_0000, 16'h0000);
      send_word(FN_SCHED_ABS,   32'h0000_0000, 16'h1234);
      send_word(FN_SCHED_ABS,   32'hFFFF_FFFF, 16'hA5A5);
      send_word(FN_SCHED_DELAY, 32'h0000_0000, 16'h5A5A);
      send_word(FN_POP_DUE,     32'h0000_0000, 16'h0000);
      send_word(FN_POP_DUE,     32'h0000_0000, 16'h0000);
      // head just beyond the limit, then exactly at it
      send_word(FN_POP_DUE,     32'h0000_FFFF, 16'h0000);
      send_word(FN_POP_DUE,     32'h0001_0000, 16'h0000);
      send_word(FN_POP,         32'h0000_0000, 16'h0000);
      // delay that overflows, then an event in the past
      send_word(FN_SCHED_DELAY, 32'hFFFF_FFFF, 16'h0F0F);
      send_word(FN_SCHED_ABS,   32'h0000_8000, 16'h00FF);
      send_word(FN_POP,         32'hFFFF_FFFF, 16'hFFFF);
      send_word(FN_SCHED_DELAY, 32'h0000_8000, 16'hF0F0);
      send_word(FN_POP,         32'h0000_0000, 16'h0000);
      send_word(FN_POP,         32'h0000_0000, 16'h0000);
      // at the largest time any delay saturates
      send_word(FN_SCHED_DELAY, 32'h0000_0001, 16'h8001);
      send_word(FN_POP_DUE,     32'hFFFF_FFFE, 16'h0000);
      send_word(FN_POP_DUE,     32'hFFFF_FFFF, 16'h0000);
      send_word(FN_POP,         32'h0000_0000, 16'h0000);
      send_word(FN_POP,         32'h0000_0000, 16'h0000);
      send_word(FN_SCHED_ABS,   32'hAAAA_AAAA, 16'h5555);
      send_word(FN_SCHED_ABS,   32'h5555_5555, 16'hAAAA);

      // Random phases: even ones fill the queue past full, odd ones drain it
      // past empty, the middle one stays balanced.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 4)
            sched_pct = 50;
         else if (phase % 2 == 0)
            sched_pct = $urandom_range(75, 95);
         else
            sched_pct = $urandom_range(5, 30);
         gaps_on    = (phase % 3 != 1);
         burst_left = 0;
         // ask the receiver for a long hold-off while words keep coming
         if (phase == 2 || phase == 7)
            stall_asked++;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (gaps_on)
                  idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            end
            burst_left--;
            random_word(sched_pct);
         end
         // hold the sender until every reply has come home
         idle_cycles(1);
         wait_replies_home();
      end

      idle_cycles(1);
      wait_replies_home();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("time_ordered_event_queue_core: match");
      else
         $display("time_ordered_event_queue_core: mismatch");
      $finish;
   end

endmodule
